/* rtl/optical_morse_receiver_assert.svh */
// Assertion macros for the optical Morse receiver.
// Included by the top level; no other dependencies.
`ifndef OPTICAL_MORSE_RECEIVER_ASSERT_SVH
`define OPTICAL_MORSE_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OMR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("omr assertion failed")
// next-cycle implication
`define OMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("omr assertion failed")
`else
`define OMR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define OMR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/omr_pkg.sv */
// Shared constants, types and the Morse look-up for the optical Morse receiver.
// No dependencies.
package omr_pkg;

   localparam int FRAME_SAMPLES    = 18;
   localparam int MESSAGE_DEPTH    = 16;
   localparam int STOP_SAMPLES     = 3;
   localparam int LEVEL_WIDTH      = 10;
   localparam int CHAR_WIDTH       = 7;
   localparam int MORSE_MAX_SYMBOLS = 5;
   localparam int MORSE_PAT_WIDTH  = 5;

   localparam int SAMPLE_IDX_WIDTH = $clog2(FRAME_SAMPLES);
   // most triples a trimmed frame can hold
   localparam int MAX_SYMBOLS      = (FRAME_SAMPLES - 1) / 3;
   localparam int GROUP_BITS       = 3 * MAX_SYMBOLS;
   localparam int SYM_COUNT_WIDTH  = ($clog2(MAX_SYMBOLS + 1) > 3) ?
                                     $clog2(MAX_SYMBOLS + 1) : 3;
   localparam int LEN_WIDTH        = $clog2(MESSAGE_DEPTH + 1);
   localparam int ADDR_WIDTH       = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;

   localparam logic [LEVEL_WIDTH-1:0] THRESHOLD_RESET = LEVEL_WIDTH'(3);

   // control codes returned by the look-up
   localparam logic [CHAR_WIDTH-1:0] CODE_NONE      = CHAR_WIDTH'(0);
   localparam logic [CHAR_WIDTH-1:0] CODE_ENTER     = CHAR_WIDTH'(1);
   localparam logic [CHAR_WIDTH-1:0] CODE_CLEAR     = CHAR_WIDTH'(2);
   localparam logic [CHAR_WIDTH-1:0] CODE_BACKSPACE = CHAR_WIDTH'(3);

   typedef enum logic [2:0] {
      EV_STORED    = 3'd0,
      EV_MSG_CHAR  = 3'd1,
      EV_MSG_END   = 3'd2,
      EV_NOT_FOUND = 3'd3,
      EV_FULL      = 3'd4
   } event_type;

   typedef struct packed {
      logic      sample_take;
      logic      decode;
      logic      lookup;
      logic      store_char;
      logic      len_clear;
      logic      len_dec;
      logic      idx_clear;
      logic      idx_inc;
      logic      mem_read;
      logic      out_load;
      event_type out_event;
      logic      out_last;
   } omr_cmd_type;

   typedef struct packed {
      logic frame_close;
      logic code_none;
      logic code_enter;
      logic code_clear;
      logic code_bksp;
      logic store_full;
      logic idx_below_len;
      logic out_free;
   } omr_stat_type;

   // symbol count and pattern (first symbol in the MSB) to ASCII or control code
   function automatic logic [CHAR_WIDTH-1:0] morse_lookup(
      input logic [2:0]                 nsym,
      input logic [MORSE_PAT_WIDTH-1:0] pat
   );
      logic [7:0] key;
      logic [CHAR_WIDTH-1:0] res;
      key = {nsym, pat};
      unique case (key)
         {3'd2, 5'd1}:  res = 7'd65;
         {3'd4, 5'd8}:  res = 7'd66;
         {3'd4, 5'd10}: res = 7'd67;
         {3'd3, 5'd4}:  res = 7'd68;
         {3'd1, 5'd0}:  res = 7'd69;
         {3'd4, 5'd2}:  res = 7'd70;
         {3'd3, 5'd6}:  res = 7'd71;
         {3'd4, 5'd0}:  res = 7'd72;
         {3'd2, 5'd0}:  res = 7'd73;
         {3'd4, 5'd7}:  res = 7'd74;
         {3'd3, 5'd5}:  res = 7'd75;
         {3'd4, 5'd4}:  res = 7'd76;
         {3'd2, 5'd3}:  res = 7'd77;
         {3'd2, 5'd2}:  res = 7'd78;
         {3'd3, 5'd7}:  res = 7'd79;
         {3'd4, 5'd6}:  res = 7'd80;
         {3'd4, 5'd13}: res = 7'd81;
         {3'd3, 5'd2}:  res = 7'd82;
         {3'd3, 5'd0}:  res = 7'd83;
         {3'd1, 5'd1}:  res = 7'd84;
         {3'd3, 5'd1}:  res = 7'd85;
         {3'd4, 5'd1}:  res = 7'd86;
         {3'd3, 5'd3}:  res = 7'd87;
         {3'd4, 5'd9}:  res = 7'd88;
         {3'd4, 5'd11}: res = 7'd89;
         {3'd4, 5'd12}: res = 7'd90;
         {3'd5, 5'd31}: res = 7'd48;
         {3'd5, 5'd15}: res = 7'd49;
         {3'd5, 5'd7}:  res = 7'd50;
         {3'd5, 5'd3}:  res = 7'd51;
         {3'd5, 5'd1}:  res = 7'd52;
         {3'd5, 5'd0}:  res = 7'd53;
         {3'd5, 5'd16}: res = 7'd54;
         {3'd5, 5'd24}: res = 7'd55;
         {3'd5, 5'd28}: res = 7'd56;
         {3'd5, 5'd30}: res = 7'd57;
         {3'd5, 5'd17}: res = CODE_ENTER;
         {3'd5, 5'd19}: res = CODE_CLEAR;
         {3'd5, 5'd23}: res = CODE_BACKSPACE;
         default:       res = CODE_NONE;
      endcase
      return res;
   endfunction

endpackage

/* rtl/optical_morse_receiver.sv */
// Optical Morse receiver, top level. Samples that open or continue a frame are
// taken while idle; a closing sample runs decode, look-up and act, then loads a
// single result, or reads and loads each stored char, then the message end.
// Output register lets the next sample beat in while the last result waits.
// Synchronous active-high reset: idle, empty message, threshold 3; store is
// not cleared (entries are only read below the message length).
`include "optical_morse_receiver_assert.svh"

module optical_morse_receiver import omr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // sample channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [LEVEL_WIDTH-1:0] req_light_level,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_event_res,
   output logic [CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                   rsp_last,
   // threshold register
   input  logic                   csr_write_en,
   input  logic [LEVEL_WIDTH-1:0] csr_light_threshold
);

   omr_cmd_type  cmd;
   omr_stat_type stat;

   // controller: sequences decode, look-up, store update and message playback
   omr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: capture shift, vote, table, store and result register
   omr_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .light_level         (req_light_level),
      .csr_write_en        (csr_write_en),
      .csr_light_threshold (csr_light_threshold),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_event_res       (rsp_event_res),
      .rsp_char_code       (rsp_char_code),
      .rsp_last            (rsp_last)
   );

   // never overwrite a result beat that has not been taken
   `OMR_ASSERT_IMPLY(a_load_free, clock, reset, cmd.out_load, stat.out_free);
   // while samples are taken, any pending result must be the closing one
   `OMR_ASSERT_IMPLY(a_idle_last, clock, reset, req_ready && rsp_valid, rsp_last);
   // a char is only stored below the store depth
   `OMR_ASSERT_IMPLY(a_store_room, clock, reset, cmd.store_char, !stat.store_full);
   // a closing sample stops sample intake on the next cycle
   `OMR_ASSERT_NEXT(a_close_busy, clock, reset,
      req_valid && req_ready && stat.frame_close, !req_ready);

endmodule

/* rtl/omr_ctrl.sv */
// Sequencing state machine for the optical Morse receiver.
// Depends on omr_pkg; drives omr_datapath through command/status structs.
module omr_ctrl import omr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  omr_stat_type stat,
   output omr_cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DECODE = 8'b0000_0010,
      ST_LOOKUP = 8'b0000_0100,
      ST_ACT    = 8'b0000_1000,
      ST_READ   = 8'b0001_0000,
      ST_CHAR   = 8'b0010_0000,
      ST_END    = 8'b0100_0000,
      ST_SINGLE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   event_type single_ev_ff, single_ev_in;

   always_comb begin
      state_in     = state_ff;
      single_ev_in = single_ev_ff;
      cmd          = '0;
      cmd.out_event = EV_STORED;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.sample_take = req_valid;
            if (req_valid && stat.frame_close) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_ACT;
         end
         ST_ACT: begin
            if (stat.code_none) begin
               single_ev_in = EV_NOT_FOUND;
               state_in     = ST_SINGLE;
            end else if (stat.code_enter) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_READ;
            end else if (stat.code_clear) begin
               cmd.len_clear = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = ST_READ;
            end else if (stat.code_bksp) begin
               cmd.len_dec   = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = ST_READ;
            end else if (stat.store_full) begin
               single_ev_in = EV_FULL;
               state_in     = ST_SINGLE;
            end else begin
               cmd.store_char = 1'b1;
               single_ev_in   = EV_STORED;
               state_in       = ST_SINGLE;
            end
         end
         ST_READ: begin
            if (stat.idx_below_len) begin
               cmd.mem_read = 1'b1;
               state_in     = ST_CHAR;
            end else begin
               state_in = ST_END;
            end
         end
         ST_CHAR: begin
            if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_event = EV_MSG_CHAR;
               cmd.idx_inc   = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_END: begin
            if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_event = EV_MSG_END;
               cmd.out_last  = 1'b1;
               cmd.len_clear = stat.code_enter;
               state_in      = ST_IDLE;
            end
         end
         ST_SINGLE: begin
            if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_event = single_ev_ff;
               cmd.out_last  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      single_ev_ff <= single_ev_in;
   end

endmodule

/* rtl/omr_datapath.sv */
// Sample capture, frame decode, message store and result register.
// Depends on omr_pkg; commanded by omr_ctrl.
module omr_datapath import omr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  omr_cmd_type            cmd,
   output omr_stat_type           stat,
   input  logic [LEVEL_WIDTH-1:0] light_level,
   input  logic                   csr_write_en,
   input  logic [LEVEL_WIDTH-1:0] csr_light_threshold,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_event_res,
   output logic [CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                   rsp_last
);

   logic [LEVEL_WIDTH-1:0]      threshold_ff, threshold_in;
   logic                        capturing_ff, capturing_in;
   logic [SAMPLE_IDX_WIDTH-1:0] count_ff, count_in;
   logic [FRAME_SAMPLES-1:0]    bits_ff, bits_in;
   logic [SYM_COUNT_WIDTH-1:0]  sym_count_ff;
   logic [MORSE_PAT_WIDTH-1:0]  pat_ff;
   logic                        frame_ok_ff;
   logic [CHAR_WIDTH-1:0]       code_ff;
   logic [LEN_WIDTH-1:0]        msg_len_ff, msg_len_in;
   logic [LEN_WIDTH-1:0]        idx_ff, idx_in;
   logic [CHAR_WIDTH-1:0]       rd_ff;
   logic [CHAR_WIDTH-1:0]       mem [MESSAGE_DEPTH];
   logic                        rsp_valid_ff, rsp_valid_in;
   event_type                   rsp_event_ff;
   logic [CHAR_WIDTH-1:0]       rsp_char_ff, out_char;
   logic                        rsp_last_ff;

   logic                        lit;
   logic                        found;
   logic [SAMPLE_IDX_WIDTH-1:0] last_lit, frame_len;
   logic                        len_valid, frame_ok;
   logic [GROUP_BITS-1:0]       kept;
   logic [MAX_SYMBOLS-1:0]      sym, started;
   logic [SYM_COUNT_WIDTH-1:0]  sym_count;
   logic [MORSE_PAT_WIDTH-1:0]  pat;

   assign lit = light_level > threshold_ff;

   // capture
   always_comb begin
      threshold_in = csr_write_en ? csr_light_threshold : threshold_ff;
      capturing_in = capturing_ff;
      count_in     = count_ff;
      bits_in      = bits_ff;
      if (cmd.sample_take) begin
         if (!capturing_ff) begin
            if (lit) begin
               capturing_in = 1'b1;
               count_in     = '0;
               bits_in      = '0;
            end
         end else begin
            if (lit) begin
               bits_in[count_ff] = 1'b1;
            end
            if (count_ff == SAMPLE_IDX_WIDTH'(FRAME_SAMPLES - 1)) begin
               capturing_in = 1'b0;
               count_in     = '0;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   // trim and majority vote
   always_comb begin
      last_lit = '0;
      found    = 1'b0;
      for (int i = 0; i < FRAME_SAMPLES; i++) begin
         if (bits_ff[i]) begin
            last_lit = SAMPLE_IDX_WIDTH'(i);
            found    = 1'b1;
         end
      end
      len_valid = found && (last_lit > SAMPLE_IDX_WIDTH'(STOP_SAMPLES - 1));
      frame_len = last_lit - SAMPLE_IDX_WIDTH'(STOP_SAMPLES - 1);
      for (int k = 0; k < GROUP_BITS; k++) begin
         kept[k] = bits_ff[k] && (SAMPLE_IDX_WIDTH'(k) < frame_len);
      end
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         sym[j] = (kept[3*j] & kept[3*j+1]) | (kept[3*j] & kept[3*j+2]) |
                  (kept[3*j+1] & kept[3*j+2]);
         started[j] = SAMPLE_IDX_WIDTH'(3*j) < frame_len;
      end
      sym_count = SYM_COUNT_WIDTH'($countones(started));
      pat = '0;
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         if (started[j]) begin
            pat = {pat[MORSE_PAT_WIDTH-2:0], sym[j]};
         end
      end
      frame_ok = len_valid && (sym_count <= SYM_COUNT_WIDTH'(MORSE_MAX_SYMBOLS));
   end

   // message length and read index
   always_comb begin
      msg_len_in = msg_len_ff;
      if (cmd.len_clear) begin
         msg_len_in = '0;
      end else if (cmd.len_dec && msg_len_ff != '0) begin
         msg_len_in = msg_len_ff - 1'b1;
      end else if (cmd.store_char) begin
         msg_len_in = msg_len_ff + 1'b1;
      end
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // result register
   always_comb begin
      case (cmd.out_event)
         EV_MSG_CHAR:         out_char = rd_ff;
         EV_STORED, EV_FULL:  out_char = code_ff;
         default:             out_char = '0;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         capturing_ff <= 1'b0;
         count_ff     <= '0;
         bits_ff      <= '0;
         msg_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         capturing_ff <= capturing_in;
         count_ff     <= count_in;
         bits_ff      <= bits_in;
         msg_len_ff   <= msg_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.decode) begin
         sym_count_ff <= sym_count;
         pat_ff       <= pat;
         frame_ok_ff  <= frame_ok;
      end
      if (cmd.lookup) begin
         code_ff <= frame_ok_ff ? morse_lookup(sym_count_ff[2:0], pat_ff) : CODE_NONE;
      end
      if (cmd.out_load) begin
         rsp_event_ff <= cmd.out_event;
         rsp_char_ff  <= out_char;
         rsp_last_ff  <= cmd.out_last;
      end
   end

   // message store
   always_ff @(posedge clock) begin
      if (cmd.store_char) begin
         mem[msg_len_ff[ADDR_WIDTH-1:0]] <= code_ff;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[idx_ff[ADDR_WIDTH-1:0]];
      end
   end

   always_comb begin
      stat.frame_close   = capturing_ff &&
                           (count_ff == SAMPLE_IDX_WIDTH'(FRAME_SAMPLES - 1));
      stat.code_none     = code_ff == CODE_NONE;
      stat.code_enter    = code_ff == CODE_ENTER;
      stat.code_clear    = code_ff == CODE_CLEAR;
      stat.code_bksp     = code_ff == CODE_BACKSPACE;
      stat.store_full    = msg_len_ff == LEN_WIDTH'(MESSAGE_DEPTH);
      stat.idx_below_len = idx_ff < msg_len_ff;
      stat.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* tb/sv/optical_morse_receiver_test.sv */
// Self-checking testbench for optical_morse_receiver: light samples in, decoded
// Morse events out. Needs omr_pkg and the receiver RTL; reads no files.
`timescale 1ns / 100ps

module optical_morse_receiver_test;
   import omr_pkg::*;

   // ---------------------------------------------------------------------------
   // Run-wide constants
   // ---------------------------------------------------------------------------
   localparam int RANDOM_ITEMS    = 400;     // frame samples wanted from the random part
   localparam int DRAIN_CYCLES    = 48;      // idle margin after the last expected beat is in
   localparam int HOLD_OFF_CYCLES = 400;     // one long receiver stall
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASE_FRAMES    = 6;       // frames between threshold changes
   localparam int MAX_REPORTS     = 10;

   // symbol patterns of the control codes, first symbol in the MSB, dash = 1
   localparam logic [4:0] PAT_ENTER     = 5'b10001;
   localparam logic [4:0] PAT_CLEAR     = 5'b10011;
   localparam logic [4:0] PAT_BACKSPACE = 5'b10111;

   typedef struct packed {
      event_type             ev;
      logic [CHAR_WIDTH-1:0] ch;
      logic                  last;
   } morse_beat;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic                   typed;   // expected beat given below, not predicted
      event_type              ev;
      logic [CHAR_WIDTH-1:0]  ch;
   } directed_row;

   // ---------------------------------------------------------------------------
   // Clock, reset and DUT signals; every input known from time zero
   // ---------------------------------------------------------------------------
   logic                   clock;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic                   req_ready;
   logic [LEVEL_WIDTH-1:0] req_light_level     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready           = 1'b0;
   logic [2:0]             rsp_event_res;
   logic [CHAR_WIDTH-1:0]  rsp_char_code;
   logic                   rsp_last;
   logic                   csr_write_en        = 1'b0;
   logic [LEVEL_WIDTH-1:0] csr_light_threshold = THRESHOLD_RESET;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   optical_morse_receiver uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_light_level     (req_light_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_char_code       (rsp_char_code),
      .rsp_last            (rsp_last),
      .csr_write_en        (csr_write_en),
      .csr_light_threshold (csr_light_threshold)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: our own copy of threshold, frame capture and message
   // ---------------------------------------------------------------------------
   logic [LEVEL_WIDTH-1:0]   threshold_now = THRESHOLD_RESET;
   bit                       in_frame      = 1'b0;
   int                       frame_pos     = 0;
   logic [FRAME_SAMPLES-1:0] frame_bits    = '0;
   logic [CHAR_WIDTH-1:0]    msg_chars [MESSAGE_DEPTH];
   int                       msg_len       = 0;

   morse_beat step_beats[$];     // beats caused by the sample just predicted
   morse_beat pending_beats[$];  // beats still owed by the DUT, oldest first

   // bookkeeping for the summary
   int fail_count     = 0;
   int beats_checked  = 0;
   int samples_sent   = 0;
   int frame_items    = 0;
   int frames_sent    = 0;
   int full_hits      = 0;
   int dumps          = 0;
   int csr_writes     = 0;
   int cycle_count    = 0;
   bit sender_eager   = 1'b0;

   // Symbol count and pattern to ASCII or control code. Letters are laid out
   // by pattern value, a dot marks a pattern with no character.
   function automatic logic [CHAR_WIDTH-1:0] char_for(input int nsym, input logic [4:0] pat);
      string row;
      byte   pick;
      row  = "";
      pick = ".";
      case (nsym)
         1: row = "ET";
         2: row = "IANM";
         3: row = "SURWDKGO";
         4: row = "HVF.L.PJBXCYZQ..";
         5: begin
            case (pat)
               5'b11111: pick = "0";
               5'b01111: pick = "1";
               5'b00111: pick = "2";
               5'b00011: pick = "3";
               5'b00001: pick = "4";
               5'b00000: pick = "5";
               5'b10000: pick = "6";
               5'b11000: pick = "7";
               5'b11100: pick = "8";
               5'b11110: pick = "9";
               PAT_ENTER:     return CODE_ENTER;
               PAT_CLEAR:     return CODE_CLEAR;
               PAT_BACKSPACE: return CODE_BACKSPACE;
               default: pick = ".";
            endcase
         end
         default: pick = ".";
      endcase
      if (row.len() != 0)
         pick = row[pat];
      return (pick == ".") ? CODE_NONE : pick[CHAR_WIDTH-1:0];
   endfunction

   // Trim trailing dark samples and the stop symbol, vote triples, look up.
   function automatic logic [CHAR_WIDTH-1:0] decode_frame(input logic [FRAME_SAMPLES-1:0] bits);
      int         last_lit;
      int         span;
      int         nsym;
      int         votes;
      logic [4:0] pat;
      last_lit = -1;
      for (int i = 0; i < FRAME_SAMPLES; i++)
         if (bits[i])
            last_lit = i;
      span = last_lit - 2;
      if (span <= 0)
         return CODE_NONE;   // nothing left once the stop symbol goes
      nsym = 0;
      pat  = '0;
      for (int t = 0; t < span; t += 3) begin
         votes = 0;
         // a short final triple counts its missing samples as dark
         for (int k = t; k < t + 3; k++)
            if (k < span && bits[k])
               votes++;
         if (nsym >= MORSE_MAX_SYMBOLS)
            return CODE_NONE;
         pat  = {pat[3:0], votes >= 2};
         nsym++;
      end
      return char_for(nsym, pat);
   endfunction

   function automatic void add_beat(input event_type ev, input logic [CHAR_WIDTH-1:0] ch);
      morse_beat b;
      b.ev   = ev;
      b.ch   = ch;
      b.last = 1'b0;
      step_beats.push_back(b);
      if (ev == EV_FULL)
         full_hits++;
   endfunction

   function automatic void dump_message();
      for (int i = 0; i < msg_len; i++)
         add_beat(EV_MSG_CHAR, msg_chars[i]);
      add_beat(EV_MSG_END, CODE_NONE);
      dumps++;
   endfunction

   // Advance the predictor by one sample; fills step_beats.
   function automatic void predict_sample(input logic [LEVEL_WIDTH-1:0] level);
      bit                    lit;
      logic [CHAR_WIDTH-1:0] code;
      morse_beat             tail;
      step_beats.delete();
      lit = level > threshold_now;
      if (!in_frame) begin
         // the opening sample is not kept
         if (lit) begin
            in_frame   = 1'b1;
            frame_pos  = 0;
            frame_bits = '0;
         end
         return;
      end
      if (lit)
         frame_bits[frame_pos] = 1'b1;
      frame_pos++;
      if (frame_pos < FRAME_SAMPLES)
         return;

      in_frame   = 1'b0;
      code       = decode_frame(frame_bits);
      frame_pos  = 0;
      frame_bits = '0;
      if (code == CODE_NONE) begin
         add_beat(EV_NOT_FOUND, CODE_NONE);
      end else if (code == CODE_ENTER) begin
         dump_message();
         msg_len = 0;
      end else if (code == CODE_CLEAR) begin
         msg_len = 0;
         dump_message();
      end else if (code == CODE_BACKSPACE) begin
         if (msg_len > 0)
            msg_len--;
         dump_message();
      end else if (msg_len >= MESSAGE_DEPTH) begin
         add_beat(EV_FULL, code);   // dropped, message unchanged
      end else begin
         msg_chars[msg_len] = code;
         msg_len++;
         add_beat(EV_STORED, code);
      end
      tail      = step_beats.pop_back();
      tail.last = 1'b1;
      step_beats.push_back(tail);
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   // mostly back to back, some short gaps, the odd long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic logic [LEVEL_WIDTH-1:0] lit_level();
      return LEVEL_WIDTH'($urandom_range(1023, int'(threshold_now) + 1));
   endfunction

   function automatic logic [LEVEL_WIDTH-1:0] dark_level();
      return LEVEL_WIDTH'($urandom_range(int'(threshold_now), 0));
   endfunction

   // Frame bits for a symbol string: each triple carries a random pattern
   // with the right majority, then a stop symbol ending on a lit sample.
   function automatic logic [FRAME_SAMPLES-1:0] frame_for(input int nsym, input logic [4:0] pat);
      logic [FRAME_SAMPLES-1:0] bits;
      logic [2:0]               trio;
      int                       r;
      bits = '0;
      for (int s = 0; s < nsym; s++) begin
         r    = $urandom_range(3, 0);
         trio = (r == 0) ? 3'b000 : 3'(1 << (r - 1));   // at most one lit: dot
         if (pat[nsym - 1 - s])
            trio = ~trio;                               // two or more lit: dash
         bits[3 * s +: 3] = trio;
      end
      bits[3 * nsym +: 3] = 3'($urandom_range(7, 0)) | 3'b100;
      return bits;
   endfunction

   // Frames off the happy path: raw noise, a short or partial tail, or
   // light only in the first three samples (no usable length).
   function automatic logic [FRAME_SAMPLES-1:0] odd_frame();
      logic [FRAME_SAMPLES-1:0] bits;
      int                       span;
      case ($urandom_range(2, 0))
         0: bits = FRAME_SAMPLES'($urandom);
         1: begin
            span = $urandom_range(15, 1);
            bits = FRAME_SAMPLES'($urandom) & FRAME_SAMPLES'((1 << (span + 3)) - 1);
            bits[span + 2] = 1'b1;
         end
         default: bits = FRAME_SAMPLES'($urandom_range(7, 0));
      endcase
      return bits;
   endfunction

   // One beat on the sample channel, with an optional idle gap in front.
   task automatic drive_sample(input logic [LEVEL_WIDTH-1:0] level);
      int gap;
      gap = sender_eager ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_light_level <= level;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      samples_sent++;
   endtask

   task automatic push_sample(input logic [LEVEL_WIDTH-1:0] level);
      predict_sample(level);
      foreach (step_beats[i])
         pending_beats.push_back(step_beats[i]);
      drive_sample(level);
   endtask

   // Threshold write with the block idle: all beats in, then a latency margin.
   task automatic retune(input logic [LEVEL_WIDTH-1:0] value);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en        <= 1'b1;
      csr_light_threshold <= value;
      threshold_now = value;
      csr_writes++;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   int frames_in_phase = 0;
   int phase_no        = 0;

   // Optional dark lead-in, a lit opener, then the frame itself. Threshold
   // changes fall between frames, never inside one.
   task automatic send_frame(input logic [FRAME_SAMPLES-1:0] bits);
      sender_eager = ($urandom_range(3, 0) == 0);
      if ($urandom_range(4, 0) == 0)
         repeat ($urandom_range(3, 1)) push_sample(dark_level());
      push_sample(lit_level());
      for (int i = 0; i < FRAME_SAMPLES; i++)
         push_sample(bits[i] ? lit_level() : dark_level());
      frame_items += FRAME_SAMPLES + 1;
      frames_sent++;
      frames_in_phase++;
      if (frames_in_phase == PHASE_FRAMES) begin
         frames_in_phase = 0;
         phase_no++;
         case (phase_no % 5)
            0: retune('0);                       // only level 0 is dark
            1: retune(LEVEL_WIDTH'(1022));       // only full scale is lit
            2: retune(LEVEL_WIDTH'($urandom_range(1021, 1)));
            3: begin
               // nothing can be lit: noise must be ignored
               retune('1);
               repeat (8) push_sample(LEVEL_WIDTH'($urandom_range(1023, 0)));
               retune(THRESHOLD_RESET);
            end
            default: retune(LEVEL_WIDTH'($urandom_range(1021, 900)));
         endcase
      end
   endtask

   // ---------------------------------------------------------------------------
   // Directed samples, at the reset threshold of 3: idle levels either side
   // of the threshold, then a frame whose last lit sample is sample 2, which
   // leaves nothing after the stop symbol is trimmed.
   // ---------------------------------------------------------------------------
   localparam directed_row DIRECTED [22] = '{
      '{10'd0,    1'b0, EV_STORED,    CODE_NONE},   // dark, ignored while idle
      '{10'd3,    1'b0, EV_STORED,    CODE_NONE},   // equal to threshold: dark
      '{10'd1,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd4,    1'b0, EV_STORED,    CODE_NONE},   // just above: opens frame
      '{10'd3,    1'b0, EV_STORED,    CODE_NONE},   // sample 0
      '{10'd1023, 1'b0, EV_STORED,    CODE_NONE},   // sample 1, full scale
      '{10'd512,  1'b0, EV_STORED,    CODE_NONE},   // sample 2, last lit
      '{10'd0,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd2,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd1,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd3,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd0,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd3,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd2,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd1,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd0,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd1,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd2,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd3,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd0,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd2,    1'b0, EV_STORED,    CODE_NONE},
      '{10'd0,    1'b1, EV_NOT_FOUND, CODE_NONE}    // sample 17 closes: not found
   };

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      morse_beat             typed_beat;
      int                    msg_no;
      int                    n_chars;
      int                    nsym;
      logic [4:0]            pat;
      logic [CHAR_WIDTH-1:0] ch;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset value of the threshold still in force
      for (int i = 0; i < $size(DIRECTED); i++) begin
         predict_sample(DIRECTED[i].level);
         if (DIRECTED[i].typed) begin
            typed_beat.ev   = DIRECTED[i].ev;
            typed_beat.ch   = DIRECTED[i].ch;
            typed_beat.last = 1'b1;
            pending_beats.push_back(typed_beat);
         end else begin
            foreach (step_beats[j])
               pending_beats.push_back(step_beats[j]);
         end
         drive_sample(DIRECTED[i].level);
      end
      retune(LEVEL_WIDTH'($urandom_range(200, 4)));

      // Random part, built as messages: characters with stray frames and
      // backspaces mixed in, closed by enter or clear. The first message
      // opens with a clear on an empty store, runs one char past the store
      // depth so that the full case comes up, then backspaces and enters.
      msg_no = 0;
      while (frame_items < RANDOM_ITEMS) begin
         n_chars = (msg_no == 0) ? MESSAGE_DEPTH + 1 : $urandom_range(6, 0);
         if (msg_no == 0)
            send_frame(frame_for(5, PAT_CLEAR));       // message end only
         else if ($urandom_range(3, 0) == 0)
            send_frame(frame_for(5, PAT_BACKSPACE));   // often on an empty message
         for (int c = 0; c < n_chars; c++) begin
            if ($urandom_range(5, 0) == 0)
               send_frame(odd_frame());
            if (msg_no != 0 && $urandom_range(6, 0) == 0)
               send_frame(frame_for(5, PAT_BACKSPACE));
            do begin
               nsym = $urandom_range(5, 1);
               pat  = 5'($urandom_range((1 << nsym) - 1, 0));
               ch   = char_for(nsym, pat);
            end while (ch <= CODE_BACKSPACE);   // letters and digits only
            send_frame(frame_for(nsym, pat));
         end
         if (msg_no == 0)
            send_frame(frame_for(5, PAT_BACKSPACE));   // long dump from a full store
         if (msg_no != 0 && $urandom_range(2, 0) == 0)
            send_frame(frame_for(5, PAT_CLEAR));
         else
            send_frame(frame_for(5, PAT_ENTER));
         msg_no++;
      end

      // drain: every beat in, then the latency margin for stray ones
      req_valid <= 1'b0;
      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d samples sent, %0d frames, %0d message dumps, %0d beats checked",
               samples_sent, frames_sent, dumps, beats_checked);
      $display("%0d store-full drops, %0d threshold writes, %0d mismatches",
               full_hits, csr_writes, fail_count);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Result side: random stalls, one long hold-off once a message dump has
   // begun (the sender keeps offering samples, so the input backs up), and
   // the comparison of every accepted beat with the oldest expectation.
   // ---------------------------------------------------------------------------
   int stall_left = 0;
   bit held_off   = 1'b0;
   bit rsp_steady = 1'b0;

   task automatic note_mismatch(input string what, input morse_beat want);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("beat %0d %s: expected ev %0d char %0d last %0b, got ev %0d char %0d last %0b",
                  beats_checked, what, want.ev, want.ch, want.last,
                  rsp_event_res, rsp_char_code, rsp_last);
   endtask

   always @(posedge clock) begin
      morse_beat want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (pending_beats.size() == 0) begin
               want = '0;
               note_mismatch("unexpected", want);
            end else begin
               want = pending_beats.pop_front();
               if (rsp_event_res !== want.ev || rsp_char_code !== want.ch ||
                   rsp_last !== want.last)
                  note_mismatch("wrong", want);
            end
         end

         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (!held_off && rsp_valid && rsp_event_res == EV_MSG_CHAR) begin
            held_off   <= 1'b1;
            stall_left <= HOLD_OFF_CYCLES;
            rsp_ready  <= 1'b0;
         end else if (!rsp_steady && $urandom_range(3, 0) == 0) begin
            stall_left <= pick_gap();
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         // spells with no random stalls
         if ($urandom_range(63, 0) == 0)
            rsp_steady <= !rsp_steady;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, pending_beats.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
